[rtl/slt_pkg.sv]
`timescale 1ns / 1ps
package slt_pkg;

  // Number of leading word characters kept for keyword matching
  localparam int WordKeepDef = 16;

  // Keyword table
  localparam int NumKw    = 79;
  localparam int KwMaxLen = 13;
  localparam int KwIdxW   = 7;

  localparam logic [KwIdxW-1:0] KwFalse = KwIdxW'(32);
  localparam logic [KwIdxW-1:0] KwFunc  = KwIdxW'(35);
  localparam int                KwRecordPos = 53;
  localparam int                KwFalsePos  = 32;
  localparam int                KwTruePos   = 67;
  localparam logic [KwIdxW-1:0] KwTrue  = KwIdxW'(67);

  // Right-justified text, zero padded on the left
  localparam logic [KwMaxLen*8-1:0] KwText [NumKw] = '{
    "Alias", "And", "Block", "Break", "Catch", "Ciao", "Clear", "Continue", "Define",
    "DegLex", "DegRevLex", "Delete", "Describe", "Destroy", "Do", "Elif", "Else", "End",
    "EndAlias", "EndBlock", "EndCatch", "EndDefine", "EndForeach", "EndFor", "EndFunc",
    "EndIf", "EndPackage", "EndRepeat", "EndTry", "EndUsing", "EndWhile", "Export",
    "False", "Foreach", "For", "Func", "If", "ImportByRef", "ImportByValue", "In",
    "IsDefined", "IsIn", "Lex", "Load", "On", "Opt", "Or", "Package", "PosTo",
    "PrintLn", "Print", "Protect", "Quit", "Record", "Ref", "Repeat", "Return", "Set",
    "Skip", "Source", "SourceRegion", "Step", "Then", "Time", "To", "TopLevel",
    "ToPos", "True", "Try", "Unset", "UponError", "Until", "Unprotect", "Use",
    "Using", "Var", "Weights", "While", "Xel"
  };

  // Result kinds
  localparam logic [1:0] ItemToken = 2'd0;
  localparam logic [1:0] ItemWarn  = 2'd1;
  localparam logic [1:0] ItemError = 2'd2;

  // Token kinds
  localparam logic [5:0] TkEof      = 6'd0;
  localparam logic [5:0] TkKeyword  = 6'd1;
  localparam logic [5:0] TkIdent    = 6'd2;
  localparam logic [5:0] TkInt      = 6'd3;
  localparam logic [5:0] TkFloat    = 6'd4;
  localparam logic [5:0] TkString   = 6'd5;
  localparam logic [5:0] TkPkg      = 6'd6;
  localparam logic [5:0] TkHelp     = 6'd7;
  localparam logic [5:0] TkSemi     = 6'd8;
  localparam logic [5:0] TkPipe     = 6'd9;
  localparam logic [5:0] TkPower    = 6'd10;
  localparam logic [5:0] TkComma    = 6'd11;
  localparam logic [5:0] TkMod      = 6'd12;
  localparam logic [5:0] TkPlus     = 6'd13;
  localparam logic [5:0] TkLRound   = 6'd14;
  localparam logic [5:0] TkRRound   = 6'd15;
  localparam logic [5:0] TkLSq      = 6'd16;
  localparam logic [5:0] TkRSq      = 6'd17;
  localparam logic [5:0] TkCompat   = 6'd18;
  localparam logic [5:0] TkStar     = 6'd19;
  localparam logic [5:0] TkEqual    = 6'd20;
  localparam logic [5:0] TkLe       = 6'd21;
  localparam logic [5:0] TkNe       = 6'd22;
  localparam logic [5:0] TkLShift   = 6'd23;
  localparam logic [5:0] TkLt       = 6'd24;
  localparam logic [5:0] TkGe       = 6'd25;
  localparam logic [5:0] TkCart     = 6'd26;
  localparam logic [5:0] TkGt       = 6'd27;
  localparam logic [5:0] TkEllipsis = 6'd28;
  localparam logic [5:0] TkDotDot   = 6'd29;
  localparam logic [5:0] TkDot      = 6'd30;
  localparam logic [5:0] TkMinus    = 6'd31;
  localparam logic [5:0] TkSlash    = 6'd32;
  localparam logic [5:0] TkAssign   = 6'd33;
  localparam logic [5:0] TkRAssign  = 6'd34;
  localparam logic [5:0] TkColCol   = 6'd35;
  localparam logic [5:0] TkColon    = 6'd36;

  // Message codes
  localparam logic [3:0] MsgNestedComment = 4'd0;
  localparam logic [3:0] MsgSingleQuote   = 4'd1;
  localparam logic [3:0] MsgKwCasing      = 4'd2;
  localparam logic [3:0] MsgCompatSemi    = 4'd3;
  localparam logic [3:0] MsgCompatFunc    = 4'd4;
  localparam logic [3:0] MsgUnknownSym    = 4'd5;
  localparam logic [3:0] MsgOpenComment   = 4'd6;
  localparam logic [3:0] MsgOpenString    = 4'd7;
  localparam logic [3:0] MsgBadHex        = 4'd8;
  localparam logic [3:0] MsgBadEscape     = 4'd9;
  localparam logic [3:0] MsgNewlineInStr  = 4'd10;
  localparam logic [3:0] MsgImplicitMul   = 4'd11;

  typedef struct packed {
    logic [7:0] source_byte;
  } in_t;

  typedef struct packed {
    logic strict_truth_words;
  } cfg_t;

  typedef struct packed {
    logic [1:0]  item_kind;
    logic [5:0]  token_kind;
    logic [6:0]  keyword_index;
    logic [31:0] start_pos;
    logic [31:0] end_pos;
    logic [3:0]  message_code;
    logic        last_of_run;
  } res_t;

  // Count characters of a padded keyword
  function automatic int kw_len(logic [KwMaxLen*8-1:0] t);
    int n;
    n = 0;
    for (int i = 0; i < KwMaxLen; i++) begin
      if (t[i*8 +: 8] != 8'h00) n++;
    end
    return n;
  endfunction

  function automatic logic [7:0] to_lower(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

endpackage

[rtl/slt_stream_if.sv]
`timescale 1ns / 1ps
interface slt_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

[rtl/script_language_tokenizer_top.sv]
`timescale 1ns / 1ps
// Latency: results of a byte are registered in the cycle it is taken, first one out next cycle.
// Throughput: one byte per cycle while each byte gives at most one result and out_o is ready;
// a byte that gives more results stalls the input while the result queue drains.
// Keyword lookup compares the stored word against all 79 keywords at once at word end.
// Reset: rst_ni low clears mode, flags, positions and the result queue; word store is not.
module script_language_tokenizer_top #(
  parameter int WordKeep = slt_pkg::WordKeepDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  slt_stream_if.sink    in_i,
  slt_stream_if.source  out_o,
  slt_stream_if.sink    cfg_i
);
  import slt_pkg::*;

  localparam int LenW = $clog2(WordKeep + 2);
  localparam int IdxW = $clog2(WordKeep);

  typedef enum logic [4:0] {
    ModeIdle, ModeStar1, ModeStar2, ModeDot1, ModeDot2, ModeColon1, ModeColon2,
    ModeLt, ModeGt, ModeMinus, ModeSlash, ModeLineC, ModeBlockC, ModeHelp, ModeStr,
    ModeNum, ModeNumDot, ModeFloat, ModePkg, ModeWord, ModeWord1C
  } mode_e;

  mode_e            mode_q, mode_d;
  logic [31:0]      pos_q, ts_q, ts_d;
  logic             compat_q, compat_d;
  logic             esc_q, esc_d;
  logic [1:0]       hex_q, hex_d;
  logic             quote_q, quote_d;
  logic [7:0]       prev_q, prev_d;
  logic [LenW-1:0]  wlen_q, wlen_d;
  logic [7:0]       word_q [WordKeep];
  logic             strict_q;

  logic             wb_we;
  logic [IdxW-1:0]  wb_idx;

  res_t             res_a [4];
  res_t             res_l [4];
  logic [2:0]       n;
  logic             do_begin;

  res_t             q_q [4];
  logic [2:0]       cnt_q;
  logic             in_ready, accept, pop;

  logic [7:0]       c;
  logic [31:0]      p, s;

  assign c = in_i.data.source_byte;
  assign p = pos_q;
  assign s = ts_q;

  function automatic res_t mk(logic [1:0] it, logic [5:0] tk, logic [KwIdxW-1:0] kw,
                              logic [31:0] sp, logic [31:0] ep, logic [3:0] code);
    res_t r;
    r.item_kind     = it;
    r.token_kind    = tk;
    r.keyword_index = kw;
    r.start_pos     = sp;
    r.end_pos       = ep;
    r.message_code  = code;
    r.last_of_run   = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] x);
    return x >= "0" && x <= "9";
  endfunction

  function automatic logic is_upper(logic [7:0] x);
    return x >= "A" && x <= "Z";
  endfunction

  function automatic logic is_lower(logic [7:0] x);
    return x >= "a" && x <= "z";
  endfunction

  function automatic logic is_xdigit(logic [7:0] x);
    return is_digit(x) || (x >= "a" && x <= "f") || (x >= "A" && x <= "F");
  endfunction

  function automatic logic is_word(logic [7:0] x);
    return is_upper(x) || is_lower(x) || is_digit(x) || x == "_";
  endfunction

  // Compare the stored word against every keyword
  logic [NumKw-1:0] kw_fold, kw_exact, kw_lower;

  for (genvar k = 0; k < NumKw; k++) begin : g_kw
    localparam int L = kw_len(KwText[k]);
    always_comb begin
      logic [7:0] ch;
      kw_fold[k]  = (wlen_q == LenW'(L));
      kw_exact[k] = kw_fold[k];
      kw_lower[k] = kw_fold[k];
      for (int i = 0; i < L; i++) begin
        ch = KwText[k][(L-1-i)*8 +: 8];
        kw_fold[k]  = kw_fold[k] & (to_lower(word_q[i]) == to_lower(ch));
        kw_exact[k] = kw_exact[k] & (word_q[i] == ch);
        kw_lower[k] = kw_lower[k] & (word_q[i] == to_lower(ch));
      end
    end
  end

  logic [KwIdxW-1:0] kw_idx;
  logic              kw_hit, kw_warn, is_record, is_true, is_false;

  always_comb begin
    kw_idx = '0;
    for (int k = 0; k < NumKw; k++) begin
      if (kw_fold[k]) kw_idx = KwIdxW'(k);
    end
  end

  assign kw_hit    = |kw_fold;
  assign kw_warn   = |(kw_fold & ~kw_exact & ~kw_lower);
  assign is_record = kw_fold[KwRecordPos] &&
                     ({word_q[0], word_q[1], word_q[2], word_q[3], word_q[4], word_q[5]}
                      == "RECORD");
  assign is_true   = kw_fold[KwTruePos] &&
                     ({word_q[0], word_q[1], word_q[2], word_q[3]} == "TRUE");
  assign is_false  = kw_fold[KwFalsePos] &&
                     ({word_q[0], word_q[1], word_q[2], word_q[3], word_q[4]} == "FALSE");

  // Work out the next state and the results of one byte
  always_comb begin
    mode_d   = mode_q;
    ts_d     = ts_q;
    compat_d = compat_q;
    esc_d    = esc_q;
    hex_d    = hex_q;
    quote_d  = quote_q;
    prev_d   = prev_q;
    wlen_d   = wlen_q;
    wb_we    = 1'b0;
    wb_idx   = '0;
    do_begin = 1'b0;
    n        = 3'd0;
    res_a    = '{default: '0};

    case (mode_q)
      ModeStar1: begin
        if (c == "*") mode_d = ModeStar2;
        else begin
          res_a[n[1:0]] = mk(ItemToken, TkStar, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeStar2: begin
        if (c == "*") begin
          compat_d = ~compat_q;
          res_a[n[1:0]] = mk(ItemToken, TkCompat, '0, s, p, '0); n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkStar, '0, s, s, '0); n = n + 3'd1;
          res_a[n[1:0]] = mk(ItemToken, TkStar, '0, s + 32'd1, s + 32'd1, '0);
          n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeDot1: begin
        if (c == ".") mode_d = ModeDot2;
        else begin
          res_a[n[1:0]] = mk(ItemToken, TkDot, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeDot2: begin
        if (c == ".") begin
          res_a[n[1:0]] = mk(ItemToken, TkEllipsis, '0, s, p, '0); n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkDotDot, '0, s, p - 32'd1, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeColon1: begin
        if (c == "=") begin
          res_a[n[1:0]] = mk(ItemToken, TkAssign, '0, s, p, '0); n = n + 3'd1;
          mode_d = ModeIdle;
        end else if (c == ":") mode_d = ModeColon2;
        else begin
          res_a[n[1:0]] = mk(ItemToken, TkColon, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeColon2: begin
        if (c == "=") begin
          res_a[n[1:0]] = mk(ItemToken, TkRAssign, '0, s, p, '0); n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkColCol, '0, s, p - 32'd1, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeLt: begin
        if (c == "=" || c == ">" || c == "<") begin
          res_a[n[1:0]] = mk(ItemToken, (c == "=") ? TkLe : (c == ">") ? TkNe : TkLShift,
                             '0, s, p, '0);
          n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkLt, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeGt: begin
        if (c == "=" || c == "<") begin
          res_a[n[1:0]] = mk(ItemToken, (c == "=") ? TkGe : TkCart, '0, s, p, '0);
          n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkGt, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeMinus: begin
        if (c == "-") mode_d = ModeLineC;
        else begin
          res_a[n[1:0]] = mk(ItemToken, TkMinus, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeSlash: begin
        if (c == "/") mode_d = ModeLineC;
        else if (c == "*") begin
          prev_d = " ";
          mode_d = ModeBlockC;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkSlash, '0, s, s, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeLineC: begin
        if (c == "\n") mode_d = ModeIdle;
        else if (c == 8'h00) do_begin = 1'b1;
      end
      ModeBlockC: begin
        if (c == 8'h00) begin
          res_a[n[1:0]] = mk(ItemError, TkEof, '0, s,
                             (p - s == 32'd2) ? s : p - 32'd1, MsgOpenComment);
          n = n + 3'd1;
          do_begin = 1'b1;
        end else begin
          if (prev_q == "/" && c == "*") begin
            res_a[n[1:0]] = mk(ItemWarn, TkEof, '0, p - 32'd1, p, MsgNestedComment);
            n = n + 3'd1;
          end
          if (prev_q == "*" && c == "/") begin
            prev_d = " ";
            mode_d = ModeIdle;
          end else prev_d = c;
        end
      end
      ModeHelp: begin
        if (c == "\n" || c == 8'h00) begin
          res_a[n[1:0]] = mk(ItemToken, TkHelp, '0, s, p - 32'd1, '0); n = n + 3'd1;
          if (c == 8'h00) do_begin = 1'b1;
          else mode_d = ModeIdle;
        end
      end
      ModeStr: begin
        if (hex_q != 2'd0) begin
          // Inside a two-digit hex escape
          if (c == 8'h00) begin
            res_a[n[1:0]] = mk(ItemError, TkEof, '0, s,
                               p - ((hex_q == 2'd2) ? 32'd1 : 32'd2), MsgOpenString);
            n = n + 3'd1;
            do_begin = 1'b1;
          end else if (!is_xdigit(c)) begin
            res_a[n[1:0]] = mk(ItemError, TkEof, '0,
                               p - ((hex_q == 2'd2) ? 32'd1 : 32'd2), p, MsgBadHex);
            n = n + 3'd1;
            mode_d = ModeIdle;
          end else hex_d = hex_q - 2'd1;
        end else if (c == 8'h00) begin
          res_a[n[1:0]] = mk(ItemError, TkEof, '0, s, p - 32'd1, MsgOpenString);
          n = n + 3'd1;
          do_begin = 1'b1;
        end else if (c == (quote_q ? 8'h27 : 8'h22) && !esc_q) begin
          res_a[n[1:0]] = mk(ItemToken, TkString, '0, s, p, '0); n = n + 3'd1;
          mode_d = ModeIdle;
        end else begin
          if (esc_q) begin
            case (c)
              "n", "r", "t", "a", 8'h27, 8'h22, 8'h5C: ;
              "x": hex_d = 2'd2;
              default: begin
                res_a[n[1:0]] = mk(ItemError, TkEof, '0, p - 32'd1, p, MsgBadEscape);
                n = n + 3'd1;
              end
            endcase
          end
          esc_d = !esc_q && c == 8'h5C;
          if (c == "\n") begin
            res_a[n[1:0]] = mk(ItemError, TkEof, '0, p, p, MsgNewlineInStr);
            n = n + 3'd1;
          end
        end
      end
      ModeNum: begin
        if (c == ".") mode_d = ModeNumDot;
        else if (!is_digit(c)) begin
          res_a[n[1:0]] = mk(ItemToken, TkInt, '0, s, p - 32'd1, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeNumDot: begin
        if (is_digit(c)) mode_d = ModeFloat;
        else begin
          // Integer followed by a dot operator
          res_a[n[1:0]] = mk(ItemToken, TkInt, '0, s, p - 32'd2, '0); n = n + 3'd1;
          ts_d = p - 32'd1;
          if (c == ".") mode_d = ModeDot2;
          else begin
            res_a[n[1:0]] = mk(ItemToken, TkDot, '0, p - 32'd1, p - 32'd1, '0);
            n = n + 3'd1;
            do_begin = 1'b1;
          end
        end
      end
      ModeFloat: begin
        if (!is_digit(c)) begin
          res_a[n[1:0]] = mk(ItemToken, TkFloat, '0, s, p - 32'd1, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModePkg: begin
        if (!(is_word(c) || c == "/")) begin
          res_a[n[1:0]] = mk(ItemToken, TkPkg, '0, s, p - 32'd1, '0); n = n + 3'd1;
          do_begin = 1'b1;
        end
      end
      ModeWord: begin
        if (is_word(c)) begin
          if (wlen_q < LenW'(WordKeep)) begin
            wb_we  = 1'b1;
            wb_idx = wlen_q[IdxW-1:0];
          end
          if (wlen_q < LenW'(WordKeep + 1)) wlen_d = wlen_q + LenW'(1);
        end else begin
          // Classify the finished word
          if (is_record) begin
            res_a[n[1:0]] = mk(ItemToken, TkIdent, '0, s, p - 32'd1, '0); n = n + 3'd1;
          end else if (!strict_q && is_true) begin
            res_a[n[1:0]] = mk(ItemToken, TkKeyword, KwTrue, s, p - 32'd1, '0);
            n = n + 3'd1;
          end else if (!strict_q && is_false) begin
            res_a[n[1:0]] = mk(ItemToken, TkKeyword, KwFalse, s, p - 32'd1, '0);
            n = n + 3'd1;
          end else if (kw_hit) begin
            if (kw_warn) begin
              res_a[n[1:0]] = mk(ItemWarn, TkEof, '0, s, p - 32'd1, MsgKwCasing);
              n = n + 3'd1;
            end
            if (kw_idx == KwFunc && compat_q) begin
              compat_d = 1'b0;
              res_a[n[1:0]] = mk(ItemError, TkEof, '0, s, p - 32'd1, MsgCompatFunc);
              n = n + 3'd1;
            end
            res_a[n[1:0]] = mk(ItemToken, TkKeyword, kw_idx, s, p - 32'd1, '0);
            n = n + 3'd1;
          end else begin
            res_a[n[1:0]] = mk(ItemToken, TkIdent, '0, s, p - 32'd1, '0); n = n + 3'd1;
          end
          do_begin = 1'b1;
        end
      end
      ModeWord1C: begin
        if (is_upper(c)) begin
          res_a[n[1:0]] = mk(ItemError, TkEof, '0, s, p, MsgImplicitMul); n = n + 3'd1;
        end else begin
          res_a[n[1:0]] = mk(ItemToken, TkIdent, '0, s, s, '0); n = n + 3'd1;
        end
        do_begin = 1'b1;
      end
      default: do_begin = 1'b1;
    endcase

    // Start a new token with this byte
    if (do_begin) begin
      mode_d = ModeIdle;
      ts_d   = p;
      case (c)
        " ", "\n", "\r", "\t", 8'h0C: ;
        8'h00: begin
          res_a[n[1:0]] = mk(ItemToken, TkEof, '0, p, p, '0); n = n + 3'd1;
        end
        ";": begin
          if (compat_d) begin
            compat_d = 1'b0;
            res_a[n[1:0]] = mk(ItemError, TkEof, '0, p, p, MsgCompatSemi); n = n + 3'd1;
          end
          res_a[n[1:0]] = mk(ItemToken, TkSemi, '0, p, p, '0); n = n + 3'd1;
        end
        "|": begin res_a[n[1:0]] = mk(ItemToken, TkPipe, '0, p, p, '0); n = n + 3'd1; end
        "^": begin res_a[n[1:0]] = mk(ItemToken, TkPower, '0, p, p, '0); n = n + 3'd1; end
        ",": begin res_a[n[1:0]] = mk(ItemToken, TkComma, '0, p, p, '0); n = n + 3'd1; end
        "%": begin res_a[n[1:0]] = mk(ItemToken, TkMod, '0, p, p, '0); n = n + 3'd1; end
        "+": begin res_a[n[1:0]] = mk(ItemToken, TkPlus, '0, p, p, '0); n = n + 3'd1; end
        "(": begin res_a[n[1:0]] = mk(ItemToken, TkLRound, '0, p, p, '0); n = n + 3'd1; end
        ")": begin res_a[n[1:0]] = mk(ItemToken, TkRRound, '0, p, p, '0); n = n + 3'd1; end
        "[": begin res_a[n[1:0]] = mk(ItemToken, TkLSq, '0, p, p, '0); n = n + 3'd1; end
        "]": begin res_a[n[1:0]] = mk(ItemToken, TkRSq, '0, p, p, '0); n = n + 3'd1; end
        "=": begin res_a[n[1:0]] = mk(ItemToken, TkEqual, '0, p, p, '0); n = n + 3'd1; end
        "*": mode_d = ModeStar1;
        "<": mode_d = ModeLt;
        ">": mode_d = ModeGt;
        "$": mode_d = ModePkg;
        ".": mode_d = ModeDot1;
        "-": mode_d = ModeMinus;
        "?": mode_d = ModeHelp;
        "/": mode_d = ModeSlash;
        ":": mode_d = ModeColon1;
        8'h27: begin
          res_a[n[1:0]] = mk(ItemWarn, TkEof, '0, p, p, MsgSingleQuote); n = n + 3'd1;
          quote_d = 1'b1;
          esc_d   = 1'b0;
          hex_d   = 2'd0;
          mode_d  = ModeStr;
        end
        8'h22: begin
          quote_d = 1'b0;
          esc_d   = 1'b0;
          hex_d   = 2'd0;
          mode_d  = ModeStr;
        end
        default: begin
          if (is_upper(c) || is_lower(c) || c == "_") begin
            if (compat_d && is_lower(c)) mode_d = ModeWord1C;
            else begin
              wb_we  = 1'b1;
              wb_idx = '0;
              wlen_d = LenW'(1);
              mode_d = ModeWord;
            end
          end else if (is_digit(c)) mode_d = ModeNum;
          else begin
            res_a[n[1:0]] = mk(ItemError, TkEof, '0, p, p, MsgUnknownSym); n = n + 3'd1;
          end
        end
      endcase
    end
  end

  // Mark the last result of the byte
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      res_l[i]             = res_a[i];
      res_l[i].last_of_run = (3'(i) + 3'd1 == n);
    end
  end

  // Take a byte when the queue is empty or its last entry leaves now
  assign pop      = out_o.valid && out_o.ready;
  assign in_ready = (cnt_q == 3'd0) || (cnt_q == 3'd1 && out_o.ready);
  assign accept   = in_i.valid && in_ready;

  assign in_i.ready  = in_ready;
  assign cfg_i.ready = 1'b1;
  assign out_o.valid = (cnt_q != 3'd0);
  assign out_o.data  = q_q[0];

  // Hold lexer state, advance on each accepted byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= ModeIdle;
      pos_q    <= '0;
      ts_q     <= '0;
      compat_q <= 1'b0;
      esc_q    <= 1'b0;
      hex_q    <= 2'd0;
      quote_q  <= 1'b0;
      prev_q   <= " ";
      wlen_q   <= '0;
      strict_q <= 1'b0;
    end else begin
      if (cfg_i.valid) strict_q <= cfg_i.data.strict_truth_words;
      if (accept) begin
        mode_q   <= mode_d;
        pos_q    <= pos_q + 32'd1;
        ts_q     <= ts_d;
        compat_q <= compat_d;
        esc_q    <= esc_d;
        hex_q    <= hex_d;
        quote_q  <= quote_d;
        prev_q   <= prev_d;
        wlen_q   <= wlen_d;
      end
    end
  end

  // Store word characters
  always_ff @(posedge clk_i) begin
    if (accept && wb_we) word_q[wb_idx] <= c;
  end

  // Load the result queue or drop the delivered head
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= 3'd0;
    end else if (accept) begin
      cnt_q <= n;
    end else if (pop) begin
      cnt_q <= cnt_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      for (int i = 0; i < 4; i++) q_q[i] <= res_l[i];
    end else if (pop) begin
      for (int i = 0; i < 3; i++) q_q[i] <= q_q[i+1];
    end
  end

`ifndef SYNTH
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready && cnt_q > 3'd1))
    else $error("byte taken while queue holds several results");

  a_results_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && n != 3'd0 |=> out_o.valid)
    else $error("results of a byte not presented");

  a_token_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.item_kind == ItemToken |-> out_o.data.message_code == 4'd0)
    else $error("token carries a message code");

  a_msg_no_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.data.item_kind != ItemToken |-> out_o.data.token_kind == TkEof)
    else $error("message carries a token kind");
`endif

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
module testbench;
  import slt_pkg::*;

  localparam int Keep = WordKeepDef;
  localparam int IdleLimit = 3000;

  typedef enum int {
    LxIdle, LxStar1, LxStar2, LxDot1, LxDot2, LxColon1, LxColon2, LxLt, LxGt,
    LxMinus, LxSlash, LxLineCmt, LxBlockCmt, LxHelp, LxString, LxNum, LxNumDot,
    LxFloat, LxPkg, LxWord, LxWordLower
  } lex_mode_e;

  // Token predictor and store of expected results
  class token_scoreboard;
    res_t       want_q[$];
    int         mismatches;
    int         results_seen;
    int         bytes_seen;
    int         step_n;
    bit         strict_truth;
    lex_mode_e  mode;
    logic [7:0] wbuf[Keep];
    int         wlen;
    bit         compat;
    bit         esc_pend;
    int         hex_left;
    bit         single_q;
    logic [7:0] cmt_prev;
    logic [31:0] pos;
    logic [31:0] tstart;
    string      kw_str[NumKw];

    function new();
      logic [7:0] b;
      for (int k = 0; k < NumKw; k++) begin
        kw_str[k] = "";
        for (int j = KwMaxLen - 1; j >= 0; j--) begin
          b = KwText[k][j*8 +: 8];
          if (b != 8'h00) kw_str[k] = $sformatf("%s%c", kw_str[k], b);
        end
      end
      strict_truth = 0; mode = LxIdle; wlen = 0; compat = 0; esc_pend = 0;
      hex_left = 0; single_q = 0; cmt_prev = " "; pos = 0; tstart = 0;
    endfunction

    function void put(logic [1:0] ik, logic [5:0] tk, logic [6:0] kw,
                      logic [31:0] s, logic [31:0] e, logic [3:0] code);
      res_t r;
      if (step_n >= 4) return;
      r.item_kind = ik; r.token_kind = tk; r.keyword_index = kw;
      r.start_pos = s; r.end_pos = e; r.message_code = code; r.last_of_run = 1'b0;
      want_q.push_back(r);
      step_n++;
    endfunction

    function void tok(logic [5:0] tk, logic [31:0] s, logic [31:0] e);
      put(ItemToken, tk, '0, s, e, '0);
    endfunction

    function void warn(logic [3:0] code, logic [31:0] s, logic [31:0] e);
      put(ItemWarn, TkEof, '0, s, e, code);
    endfunction

    function void fail(logic [3:0] code, logic [31:0] s, logic [31:0] e);
      put(ItemError, TkEof, '0, s, e, code);
    endfunction

    function logic [7:0] lc(logic [7:0] c);
      return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
    endfunction

    function bit is_dig(logic [7:0] c); return c >= "0" && c <= "9"; endfunction
    function bit is_up(logic [7:0] c); return c >= "A" && c <= "Z"; endfunction
    function bit is_lo(logic [7:0] c); return c >= "a" && c <= "z"; endfunction
    function bit is_wc(logic [7:0] c);
      return is_up(c) || is_lo(c) || is_dig(c) || c == "_";
    endfunction
    function bit is_hex(logic [7:0] c);
      return is_dig(c) || (lc(c) >= "a" && lc(c) <= "f");
    endfunction

    // how: 0 exact, 1 keyword folded, 2 both folded
    function bit word_is(string t, int how);
      logic [7:0] a, b;
      int i;
      for (i = 0; i < t.len(); i++) begin
        if (i >= wlen || i >= Keep) return 0;
        a = wbuf[i]; b = t[i];
        if (how == 1) b = lc(b);
        else if (how == 2) begin a = lc(a); b = lc(b); end
        if (a != b) return 0;
      end
      return i == wlen;
    endfunction

    function void close_word(logic [31:0] e);
      if (word_is("RECORD", 0)) begin tok(TkIdent, tstart, e); return; end
      if (!strict_truth) begin
        if (word_is("TRUE", 0)) begin put(ItemToken, TkKeyword, KwTrue, tstart, e, '0); return; end
        if (word_is("FALSE", 0)) begin put(ItemToken, TkKeyword, KwFalse, tstart, e, '0); return; end
      end
      for (int k = 0; k < NumKw; k++) begin
        if (word_is(kw_str[k], 2)) begin
          if (!word_is(kw_str[k], 0) && !word_is(kw_str[k], 1)) warn(MsgKwCasing, tstart, e);
          if (k == KwFunc && compat) begin compat = 0; fail(MsgCompatFunc, tstart, e); end
          put(ItemToken, TkKeyword, KwIdxW'(k), tstart, e, '0);
          return;
        end
      end
      tok(TkIdent, tstart, e);
    endfunction

    function void start_tok(logic [7:0] c, logic [31:0] p);
      mode = LxIdle;
      tstart = p;
      case (c)
        " ", "\n", "\r", "\t", 8'h0c: return;
        8'h00: begin tok(TkEof, p, p); return; end
        ";": begin
          if (compat) begin compat = 0; fail(MsgCompatSemi, p, p); end
          tok(TkSemi, p, p); return;
        end
        "|": begin tok(TkPipe, p, p); return; end
        "^": begin tok(TkPower, p, p); return; end
        ",": begin tok(TkComma, p, p); return; end
        "%": begin tok(TkMod, p, p); return; end
        "+": begin tok(TkPlus, p, p); return; end
        "(": begin tok(TkLRound, p, p); return; end
        ")": begin tok(TkRRound, p, p); return; end
        "[": begin tok(TkLSq, p, p); return; end
        "]": begin tok(TkRSq, p, p); return; end
        "=": begin tok(TkEqual, p, p); return; end
        "*": begin mode = LxStar1; return; end
        "<": begin mode = LxLt; return; end
        ">": begin mode = LxGt; return; end
        "$": begin mode = LxPkg; return; end
        ".": begin mode = LxDot1; return; end
        "-": begin mode = LxMinus; return; end
        "?": begin mode = LxHelp; return; end
        "/": begin mode = LxSlash; return; end
        ":": begin mode = LxColon1; return; end
        "'": begin
          warn(MsgSingleQuote, p, p);
          single_q = 1; esc_pend = 0; hex_left = 0; mode = LxString; return;
        end
        "\"": begin single_q = 0; esc_pend = 0; hex_left = 0; mode = LxString; return; end
        default: ;
      endcase
      if (is_up(c) || is_lo(c) || c == "_") begin
        if (compat && is_lo(c)) begin mode = LxWordLower; return; end
        wbuf[0] = c; wlen = 1; mode = LxWord; return;
      end
      if (is_dig(c)) begin mode = LxNum; return; end
      fail(MsgUnknownSym, p, p);
    endfunction

    function void after_dot(logic [7:0] c, logic [31:0] p);
      if (c == ".") begin mode = LxDot2; return; end
      tok(TkDot, tstart, tstart);
      start_tok(c, p);
    endfunction

    function void in_string(logic [7:0] c, logic [31:0] p);
      logic [7:0] closing;
      bit esc;
      closing = single_q ? "'" : "\"";
      esc = esc_pend;
      if (hex_left == 2) begin
        if (c == 0) begin fail(MsgOpenString, tstart, p - 1); start_tok(8'h00, p); return; end
        if (!is_hex(c)) begin fail(MsgBadHex, p - 1, p); mode = LxIdle; return; end
        hex_left = 1; return;
      end
      if (hex_left == 1) begin
        if (c == 0) begin fail(MsgOpenString, tstart, p - 2); start_tok(8'h00, p); return; end
        if (!is_hex(c)) begin fail(MsgBadHex, p - 2, p); mode = LxIdle; return; end
        hex_left = 0; return;
      end
      if (c == 0) begin fail(MsgOpenString, tstart, p - 1); start_tok(8'h00, p); return; end
      if (c == closing && !esc) begin tok(TkString, tstart, p); mode = LxIdle; return; end
      if (esc) begin
        case (c)
          "n", "r", "t", "a", "'", "\"", "\\": ;
          "x": hex_left = 2;
          default: fail(MsgBadEscape, p - 1, p);
        endcase
      end
      esc_pend = !esc && c == "\\";
      if (c == "\n") fail(MsgNewlineInStr, p, p);
    endfunction

    function void feed(logic [7:0] c, logic [31:0] p);
      logic [31:0] s;
      s = tstart;
      case (mode)
        LxStar1: begin
          if (c == "*") begin mode = LxStar2; return; end
          tok(TkStar, s, s); start_tok(c, p);
        end
        LxStar2: begin
          if (c == "*") begin compat = !compat; tok(TkCompat, s, p); mode = LxIdle; return; end
          tok(TkStar, s, s); tok(TkStar, s + 1, s + 1); start_tok(c, p);
        end
        LxDot1: after_dot(c, p);
        LxDot2: begin
          if (c == ".") begin tok(TkEllipsis, s, p); mode = LxIdle; return; end
          tok(TkDotDot, s, p - 1); start_tok(c, p);
        end
        LxColon1: begin
          if (c == "=") begin tok(TkAssign, s, p); mode = LxIdle; return; end
          if (c == ":") begin mode = LxColon2; return; end
          tok(TkColon, s, s); start_tok(c, p);
        end
        LxColon2: begin
          if (c == "=") begin tok(TkRAssign, s, p); mode = LxIdle; return; end
          tok(TkColCol, s, p - 1); start_tok(c, p);
        end
        LxLt: begin
          if (c == "=") begin tok(TkLe, s, p); mode = LxIdle; return; end
          if (c == ">") begin tok(TkNe, s, p); mode = LxIdle; return; end
          if (c == "<") begin tok(TkLShift, s, p); mode = LxIdle; return; end
          tok(TkLt, s, s); start_tok(c, p);
        end
        LxGt: begin
          if (c == "=") begin tok(TkGe, s, p); mode = LxIdle; return; end
          if (c == "<") begin tok(TkCart, s, p); mode = LxIdle; return; end
          tok(TkGt, s, s); start_tok(c, p);
        end
        LxMinus: begin
          if (c == "-") begin mode = LxLineCmt; return; end
          tok(TkMinus, s, s); start_tok(c, p);
        end
        LxSlash: begin
          if (c == "/") begin mode = LxLineCmt; return; end
          if (c == "*") begin cmt_prev = " "; mode = LxBlockCmt; return; end
          tok(TkSlash, s, s); start_tok(c, p);
        end
        LxLineCmt: begin
          if (c == "\n") mode = LxIdle;
          else if (c == 0) start_tok(8'h00, p);
        end
        LxBlockCmt: begin
          if (c == 0) begin
            fail(MsgOpenComment, s, (p - s == 2) ? s : p - 1);
            start_tok(8'h00, p); return;
          end
          if (cmt_prev == "/" && c == "*") warn(MsgNestedComment, p - 1, p);
          if (cmt_prev == "*" && c == "/") begin cmt_prev = " "; mode = LxIdle; return; end
          cmt_prev = c;
        end
        LxHelp: begin
          if (c == "\n") begin tok(TkHelp, s, p - 1); mode = LxIdle; end
          else if (c == 0) begin tok(TkHelp, s, p - 1); start_tok(8'h00, p); end
        end
        LxString: in_string(c, p);
        LxNum: begin
          if (is_dig(c)) return;
          if (c == ".") begin mode = LxNumDot; return; end
          tok(TkInt, s, p - 1); start_tok(c, p);
        end
        LxNumDot: begin
          if (is_dig(c)) begin mode = LxFloat; return; end
          tok(TkInt, s, p - 2);
          tstart = p - 1;
          mode = LxDot1;
          after_dot(c, p);
        end
        LxFloat: begin
          if (is_dig(c)) return;
          tok(TkFloat, s, p - 1); start_tok(c, p);
        end
        LxPkg: begin
          if (is_wc(c) || c == "/") return;
          tok(TkPkg, s, p - 1); start_tok(c, p);
        end
        LxWord: begin
          if (is_wc(c)) begin
            if (wlen < Keep) wbuf[wlen] = c;
            if (wlen < Keep + 1) wlen++;
            return;
          end
          close_word(p - 1); start_tok(c, p);
        end
        LxWordLower: begin
          if (is_up(c)) begin fail(MsgImplicitMul, s, p); start_tok(c, p); return; end
          tok(TkIdent, s, s); start_tok(c, p);
        end
        default: start_tok(c, p);
      endcase
    endfunction

    // Note one accepted byte and queue the results it causes
    function void note_byte(logic [7:0] c);
      logic [31:0] p;
      p = pos;
      pos = p + 1;
      step_n = 0;
      bytes_seen++;
      feed(c, p);
      if (step_n > 0) want_q[want_q.size() - 1].last_of_run = 1'b1;
    endfunction

    // Compare one accepted result with the oldest expectation
    function void check_result(res_t got);
      res_t w;
      results_seen++;
      if (want_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", got);
        return;
      end
      w = want_q.pop_front();
      if (got.item_kind !== w.item_kind || got.token_kind !== w.token_kind ||
          got.keyword_index !== w.keyword_index || got.start_pos !== w.start_pos ||
          got.end_pos !== w.end_pos || got.message_code !== w.message_code ||
          got.last_of_run !== w.last_of_run) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", w, got);
      end
    endfunction
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;

  slt_stream_if #(.T(in_t))  in_if ();
  slt_stream_if #(.T(res_t)) out_if ();
  slt_stream_if #(.T(cfg_t)) cfg_if ();

  script_language_tokenizer_top DUT (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if),
    .cfg_i  (cfg_if)
  );

  token_scoreboard sb = new();
  bit calm = 0;
  bit hold_off = 0;
  int cfg_writes = 0;
  int quiet = 0;
  logic [7:0] text_q[$];

  always begin
    #5 clk_i = 1;
    #5 clk_i = 0;
  end

  initial begin
    in_if.valid = 0;
    in_if.data = '0;
    out_if.ready = 0;
    cfg_if.valid = 0;
    cfg_if.data = '0;
  end

  // Abort when nothing moves for too long
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready)) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= IdleLimit) begin
      $display("watchdog: no progress for %0d cycles", IdleLimit);
      $display("testbench NOT OK");
      $finish;
    end
  end

  // Result sink: random stalls, plus one long hold when requested
  initial begin
    int gap;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      gap = calm ? 0 : $urandom_range(0, 7);
      if (hold_off) begin
        out_if.ready = 0;
        repeat (250) @(negedge clk_i);
        hold_off = 0;
      end else if (gap > 0) begin
        out_if.ready = 0;
        repeat (gap) @(negedge clk_i);
      end
      out_if.ready = 1;
      do @(posedge clk_i); while (!out_if.valid);
      sb.check_result(out_if.data);
      @(negedge clk_i);
    end
  end

  // Send one byte; entered and left at a falling edge
  task automatic send_byte(logic [7:0] c);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 7);
    if (gap > 0) begin
      in_if.valid = 0;
      repeat (gap) @(negedge clk_i);
    end
    in_if.valid = 1;
    in_if.data.source_byte = c;
    do @(posedge clk_i); while (!in_if.ready);
    sb.note_byte(c);
    @(negedge clk_i);
  endtask

  task automatic send_text();
    while (text_q.size() > 0) send_byte(text_q.pop_front());
  endtask

  // Hold input until all results are in, then let the block settle
  task automatic drain();
    in_if.valid = 0;
    while (sb.want_q.size() > 0) @(negedge clk_i);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic write_cfg(bit v);
    cfg_if.valid = 1;
    cfg_if.data.strict_truth_words = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    sb.strict_truth = v;
    cfg_writes++;
    @(negedge clk_i);
    cfg_if.valid = 0;
  endtask

  task automatic add_str(string s);
    for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
  endtask

  function automatic logic [7:0] word_char();
    int r;
    r = $urandom_range(0, 62);
    if (r < 26) return 8'("a" + r);
    if (r < 52) return 8'("A" + r - 26);
    if (r < 62) return 8'("0" + r - 52);
    return "_";
  endfunction

  function automatic logic [7:0] hex_char();
    int r;
    r = $urandom_range(0, 15);
    return 8'((r < 10) ? "0" + r : "a" + r - 10);
  endfunction

  // Append one random lexical fragment, mostly well formed
  task automatic add_fragment();
    string ops[] = '{"*", "**", "***", "<=", "<>", "<<", "<", ">=", "><", ">", "...",
                     "..", ".", "-", "/", ":=", "::=", "::", ":", ";", "|", "^", ",",
                     "%", "+", "(", ")", "[", "]", "=", "$pkg/sub_1"};
    string specials[] = '{"TRUE", "FALSE", "RECORD", "Func", "func", "FUNC", "True"};
    string kw;
    logic [7:0] ch;
    int n;
    case ($urandom_range(0, 11))
      0, 1: begin
        kw = sb.kw_str[$urandom_range(0, NumKw - 1)];
        for (int i = 0; i < kw.len(); i++) begin
          ch = kw[i];
          if ($urandom_range(0, 3) == 0)
            ch = sb.is_up(ch) ? ch + 8'd32 : (sb.is_lo(ch) ? ch - 8'd32 : ch);
          text_q.push_back(ch);
        end
      end
      2: begin
        n = ($urandom_range(0, 4) == 0) ? $urandom_range(14, 22) : $urandom_range(1, 6);
        text_q.push_back(($urandom_range(0, 1)) ? "_" : 8'("a" + $urandom_range(0, 25)));
        repeat (n - 1) text_q.push_back(word_char());
      end
      3: begin
        repeat ($urandom_range(1, 4)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
        case ($urandom_range(0, 3))
          0: add_str(".");
          1: add_str("..");
          default: ;
        endcase
        repeat ($urandom_range(0, 3)) text_q.push_back(8'("0" + $urandom_range(0, 9)));
      end
      4: begin
        ch = ($urandom_range(0, 3) == 0) ? "'" : "\"";
        text_q.push_back(ch);
        repeat ($urandom_range(0, 6)) begin
          case ($urandom_range(0, 9))
            0: add_str("\\n");
            1: begin add_str("\\x"); text_q.push_back(hex_char()); text_q.push_back(hex_char()); end
            2: add_str("\\xg");
            3: begin add_str("\\x"); text_q.push_back(hex_char()); add_str("z"); end
            4: add_str("\\q");
            5: add_str("\n");
            6: add_str("\\\\");
            default: text_q.push_back(word_char());
          endcase
        end
        if ($urandom_range(0, 7) != 0) text_q.push_back(ch);
      end
      5: text_q.push_back(ops[$urandom_range(0, ops.size() - 1)][0]);
      6: add_str(ops[$urandom_range(0, ops.size() - 1)]);
      7: case ($urandom_range(0, 3))
        0: add_str("-- note\n");
        1: add_str("// x y\n");
        2: add_str("/* a /* b **/");
        default: add_str("? help me\n");
      endcase
      8: add_str(specials[$urandom_range(0, specials.size() - 1)]);
      9: text_q.push_back(8'($urandom_range(1, 255)));
      10: text_q.push_back($urandom_range(0, 3) == 0 ? 8'h00 : 8'h0a);
      default: add_str(" ");
    endcase
    if ($urandom_range(0, 2) != 0) text_q.push_back(($urandom_range(0, 1)) ? " " : "\t");
  endtask

  task automatic random_phase(int bytes);
    int target;
    target = sb.bytes_seen + bytes;
    while (sb.bytes_seen < target) begin
      calm = ($urandom_range(0, 5) == 0);
      add_fragment();
      send_text();
    end
    calm = 0;
  endtask

  initial begin
    repeat (4) @(negedge clk_i);
    rst_ni = 1;
    @(negedge clk_i);

    // Directed: compat toggle, compat semicolon, escapes, single quote, open string at end of input
    write_cfg(0);
    add_str("***a;bC Func***TRUE \"\\z\\xg\n'//*/* ");
    text_q.push_back(8'hff);
    text_q.push_back(8'h80);
    text_q.push_back(8'h00);
    send_text();
    drain();

    // Random with strict truth words, including a long receiver hold
    write_cfg(1);
    hold_off = 1;
    random_phase(80);
    drain();

    write_cfg(0);
    random_phase(80);
    drain();

    write_cfg(1);
    calm = 1;
    add_str("TRUE FALSE True ");
    send_text();
    random_phase(80);
    text_q.push_back(8'h00);
    send_text();
    drain();

    $display("fed %0d bytes, checked %0d results over %0d register writes",
             sb.bytes_seen, sb.results_seen, cfg_writes);
    $display("leftover expectations: %0d, mismatches: %0d", sb.want_q.size(), sb.mismatches);
    if (sb.mismatches == 0 && sb.want_q.size() == 0) begin
      $display("testbench OK");
    end else begin
      $display("testbench NOT OK");
    end
    $finish;
  end

endmodule
